// ===== rtl/cpt_pkg.sv =====
// shared widths, payload types and region codes for the closest-point block
// no dependencies; every other file imports this package
package cpt_pkg;

    localparam int CW = 16;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int EW = DOTW + 1;
    localparam int HL = DOTW / 2;
    localparam int HH = DOTW - HL;
    localparam int PPW = 2 * DOTW;
    localparam int VW = PPW + 1;
    localparam int WW = VW + 2;
    localparam int CK = (WW + 2) / 3;
    localparam int CKT = WW - 2 * CK;
    localparam int PRW = DW + WW;
    localparam int NW = PRW + 1;
    localparam int QW = CW + 2;
    localparam int CMPW = NW + 1;
    localparam int GEO_STAGES = 6;
    localparam int WGT_STAGES = 4;
    localparam int DIV_LAT = QW + 3;

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [DW-1:0]   diff_t;
    typedef logic signed [DOTW-1:0] dot_t;
    typedef logic signed [EW-1:0]   ed_t;
    typedef logic signed [PPW-1:0]  prod_t;
    typedef logic signed [VW-1:0]   v_t;
    typedef logic signed [WW-1:0]   w_t;
    typedef logic signed [NW-1:0]   num_t;

    typedef enum logic [2:0] {
        RGN_A  = 3'd0,
        RGN_B  = 3'd1,
        RGN_AB = 3'd2,
        RGN_C  = 3'd3,
        RGN_AC = 3'd4,
        RGN_BC = 3'd5,
        RGN_IN = 3'd6
    } region_t;

    typedef struct packed {
        coord_t query_x;
        coord_t query_y;
        coord_t query_z;
        coord_t vert_a_x;
        coord_t vert_a_y;
        coord_t vert_a_z;
        coord_t vert_b_x;
        coord_t vert_b_y;
        coord_t vert_b_z;
        coord_t vert_c_x;
        coord_t vert_c_y;
        coord_t vert_c_z;
    } in_item_t;

    typedef struct packed {
        coord_t     near_x;
        coord_t     near_y;
        coord_t     near_z;
        logic [2:0] region;
    } out_item_t;

    typedef struct packed {
        logic         vld;
        coord_t [2:0] a;
        coord_t [2:0] b;
        coord_t [2:0] c;
        diff_t [2:0]  ab;
        diff_t [2:0]  ac;
        diff_t [2:0]  bc;
        dot_t         d1;
        dot_t         d2;
        dot_t         d3;
        dot_t         d6;
        ed_t          e1;
        ed_t          e2;
        ed_t          f1;
        ed_t          f2;
        v_t           va;
        v_t           vb;
        v_t           vc;
    } geo_t;

    typedef struct packed {
        logic         vld;
        region_t      rg;
        coord_t [2:0] base;
        num_t [2:0]   num;
        w_t           den;
    } wgt_t;

endpackage

// ===== rtl/cpt_geom.sv =====
// front pipeline: edge vectors, six dot products and the three cross terms
// depends on cpt_pkg
module cpt_geom (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  cpt_pkg::in_item_t in_item,
    output cpt_pkg::geo_t     geo
);
    import cpt_pkg::*;

    typedef struct packed {
        coord_t [2:0] a;
        coord_t [2:0] b;
        coord_t [2:0] c;
        diff_t [2:0]  ab;
        diff_t [2:0]  ac;
        diff_t [2:0]  bc;
    } carry_t;

    typedef struct packed {
        logic signed [2*HL+1:0] ll;
        logic signed [HL+HH:0]  lh;
        logic signed [HL+HH:0]  hl;
        logic signed [2*HH-1:0] hh;
    } pp_t;

    function automatic diff_t dif(input coord_t x, input coord_t y);
        return diff_t'(DW'(x) - DW'(y));
    endfunction

    function automatic logic signed [PW-1:0] mulw(input diff_t x, input diff_t y);
        logic signed [PW-1:0] r;
        r = x * y;
        return r;
    endfunction

    function automatic pp_t mul_parts(input dot_t x, input dot_t y);
        logic signed [HL:0]   xl;
        logic signed [HL:0]   yl;
        logic signed [HH-1:0] xh;
        logic signed [HH-1:0] yh;
        pp_t                  r;
        xl = {1'b0, x[HL-1:0]};
        yl = {1'b0, y[HL-1:0]};
        xh = x[DOTW-1:HL];
        yh = y[DOTW-1:HL];
        r.ll = xl * yl;
        r.lh = xl * yh;
        r.hl = xh * yl;
        r.hh = xh * yh;
        return r;
    endfunction

    function automatic prod_t join_parts(input pp_t p);
        return (PPW'(p.hh) <<< (2 * HL)) + ((PPW'(p.lh) + PPW'(p.hl)) <<< HL)
               + PPW'(p.ll);
    endfunction

    logic [GEO_STAGES-1:0] vld_reg;
    carry_t                cr_reg [GEO_STAGES-1];
    carry_t                cr_next;
    diff_t [2:0]           ap_reg, bp_reg, cp_reg;
    diff_t [2:0]           ap_next, bp_next, cp_next;
    logic signed [PW-1:0]  pr_reg [6][3];
    logic signed [PW-1:0]  pr_next [6][3];
    dot_t                  d_reg [6];
    dot_t                  d_next [6];
    pp_t                   pp_reg [6];
    pp_t                   pp_next [6];
    dot_t                  dk_reg [6];
    prod_t                 m_reg [6];
    prod_t                 m_next [6];
    dot_t                  dm_reg [6];
    geo_t                  g_reg, g_next;

    // stage 1: differences
    always_comb
    begin
        coord_t pt [3];
        coord_t ta [3];
        coord_t tb [3];
        coord_t tc [3];
        pt[0] = in_item.query_x;
        pt[1] = in_item.query_y;
        pt[2] = in_item.query_z;
        ta[0] = in_item.vert_a_x;
        ta[1] = in_item.vert_a_y;
        ta[2] = in_item.vert_a_z;
        tb[0] = in_item.vert_b_x;
        tb[1] = in_item.vert_b_y;
        tb[2] = in_item.vert_b_z;
        tc[0] = in_item.vert_c_x;
        tc[1] = in_item.vert_c_y;
        tc[2] = in_item.vert_c_z;
        for (int i = 0; i < 3; i++)
        begin
            cr_next.a[i]  = ta[i];
            cr_next.b[i]  = tb[i];
            cr_next.c[i]  = tc[i];
            cr_next.ab[i] = dif(tb[i], ta[i]);
            cr_next.ac[i] = dif(tc[i], ta[i]);
            cr_next.bc[i] = dif(tc[i], tb[i]);
            ap_next[i]    = dif(pt[i], ta[i]);
            bp_next[i]    = dif(pt[i], tb[i]);
            cp_next[i]    = dif(pt[i], tc[i]);
        end
    end

    // stage 2: coordinate products, stage 3: dot sums
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pr_next[0][i] = mulw(cr_reg[0].ab[i], ap_reg[i]);
            pr_next[1][i] = mulw(cr_reg[0].ac[i], ap_reg[i]);
            pr_next[2][i] = mulw(cr_reg[0].ab[i], bp_reg[i]);
            pr_next[3][i] = mulw(cr_reg[0].ac[i], bp_reg[i]);
            pr_next[4][i] = mulw(cr_reg[0].ab[i], cp_reg[i]);
            pr_next[5][i] = mulw(cr_reg[0].ac[i], cp_reg[i]);
        end
        for (int k = 0; k < 6; k++)
        begin
            d_next[k] = DOTW'(pr_reg[k][0]) + DOTW'(pr_reg[k][1]) + DOTW'(pr_reg[k][2]);
        end
    end

    // stage 4: partial products, stage 5: joined cross products
    always_comb
    begin
        pp_next[0] = mul_parts(d_reg[0], d_reg[3]);
        pp_next[1] = mul_parts(d_reg[2], d_reg[1]);
        pp_next[2] = mul_parts(d_reg[4], d_reg[1]);
        pp_next[3] = mul_parts(d_reg[0], d_reg[5]);
        pp_next[4] = mul_parts(d_reg[2], d_reg[5]);
        pp_next[5] = mul_parts(d_reg[4], d_reg[3]);
        for (int j = 0; j < 6; j++)
        begin
            m_next[j] = join_parts(pp_reg[j]);
        end
    end

    // stage 6: cross terms and edge differences
    always_comb
    begin
        g_next     = '0;
        g_next.a   = cr_reg[GEO_STAGES-2].a;
        g_next.b   = cr_reg[GEO_STAGES-2].b;
        g_next.c   = cr_reg[GEO_STAGES-2].c;
        g_next.ab  = cr_reg[GEO_STAGES-2].ab;
        g_next.ac  = cr_reg[GEO_STAGES-2].ac;
        g_next.bc  = cr_reg[GEO_STAGES-2].bc;
        g_next.d1  = dm_reg[0];
        g_next.d2  = dm_reg[1];
        g_next.d3  = dm_reg[2];
        g_next.d6  = dm_reg[5];
        g_next.e1  = EW'(dm_reg[3]) - EW'(dm_reg[2]);
        g_next.e2  = EW'(dm_reg[4]) - EW'(dm_reg[5]);
        g_next.f1  = EW'(dm_reg[0]) - EW'(dm_reg[2]);
        g_next.f2  = EW'(dm_reg[1]) - EW'(dm_reg[5]);
        g_next.vc  = VW'(m_reg[0]) - VW'(m_reg[1]);
        g_next.vb  = VW'(m_reg[2]) - VW'(m_reg[3]);
        g_next.va  = VW'(m_reg[4]) - VW'(m_reg[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[GEO_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_reg[0] <= cr_next;
            for (int k = 1; k < GEO_STAGES - 1; k++)
            begin
                cr_reg[k] <= cr_reg[k-1];
            end
            ap_reg <= ap_next;
            bp_reg <= bp_next;
            cp_reg <= cp_next;
            pr_reg <= pr_next;
            d_reg  <= d_next;
            pp_reg <= pp_next;
            dk_reg <= d_reg;
            m_reg  <= m_next;
            dm_reg <= dk_reg;
            g_reg  <= g_next;
        end
    end

    always_comb
    begin
        geo     = g_reg;
        geo.vld = vld_reg[GEO_STAGES-1];
    end

endmodule

// ===== rtl/cpt_weight.sv =====
// region decision and weighted offset numerators for each coordinate
// depends on cpt_pkg
module cpt_weight (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  cpt_pkg::geo_t geo,
    output cpt_pkg::wgt_t wgt
);
    import cpt_pkg::*;

    localparam int LPW = DW + CK + 1;
    localparam int TPW = DW + CKT;

    typedef struct packed {
        region_t      rg;
        coord_t [2:0] base;
        w_t           den;
    } side_t;

    logic [WGT_STAGES-1:0] vld_reg;
    side_t                 side_reg [WGT_STAGES];
    side_t                 side_next;
    diff_t [2:0]           dira_reg, dirb_reg, dira_next, dirb_next;
    w_t                    wa_reg, wb_reg, wa_next, wb_next;
    logic signed [LPW-1:0] pl_reg [3][2][2];
    logic signed [LPW-1:0] pl_next [3][2][2];
    logic signed [TPW-1:0] pt_reg [3][2];
    logic signed [TPW-1:0] pt_next [3][2];
    logic signed [PRW-1:0] pr_reg [3][2];
    logic signed [PRW-1:0] pr_next [3][2];
    num_t [2:0]            num_reg, num_next;

    // stage 7: region and operand selection
    always_comb
    begin
        region_t rg;
        if (geo.d1 <= 0 && geo.d2 <= 0)
            rg = RGN_A;
        else if (geo.d3 >= 0 && geo.e1 <= 0)
            rg = RGN_B;
        else if (geo.vc <= 0 && geo.d1 >= 0 && geo.d3 <= 0)
            rg = RGN_AB;
        else if (geo.d6 >= 0 && geo.e2 <= 0)
            rg = RGN_C;
        else if (geo.vb <= 0 && geo.d2 >= 0 && geo.d6 <= 0)
            rg = RGN_AC;
        else if (geo.va <= 0 && geo.e1 >= 0 && geo.e2 >= 0)
            rg = RGN_BC;
        else
            rg = RGN_IN;

        side_next.rg   = rg;
        side_next.base = geo.a;
        side_next.den  = w_t'(1);
        dira_next      = geo.ab;
        dirb_next      = geo.ac;
        wa_next        = '0;
        wb_next        = '0;
        case (rg)
            RGN_A:
            begin
                side_next.base = geo.a;
            end
            RGN_B:
            begin
                side_next.base = geo.b;
            end
            RGN_AB:
            begin
                wa_next       = WW'(geo.d1);
                side_next.den = WW'(geo.f1);
            end
            RGN_C:
            begin
                side_next.base = geo.c;
            end
            RGN_AC:
            begin
                dira_next     = geo.ac;
                wa_next       = WW'(geo.d2);
                side_next.den = WW'(geo.f2);
            end
            RGN_BC:
            begin
                side_next.base = geo.b;
                dira_next      = geo.bc;
                wa_next        = WW'(geo.e1);
                side_next.den  = WW'(geo.e1) + WW'(geo.e2);
            end
            RGN_IN:
            begin
                wa_next       = WW'(geo.vb);
                wb_next       = WW'(geo.vc);
                side_next.den = WW'(geo.va) + WW'(geo.vb) + WW'(geo.vc);
            end
            default:
            begin
                side_next.base = geo.a;
            end
        endcase
    end

    // stage 8: chunk products, stage 9: joined products, stage 10: numerators
    always_comb
    begin
        diff_t                dir;
        w_t                   w;
        logic signed [CK:0]   c0;
        logic signed [CK:0]   c1;
        logic signed [CKT-1:0] c2;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                dir = (j == 0) ? dira_reg[i] : dirb_reg[i];
                w   = (j == 0) ? wa_reg : wb_reg;
                c0  = {1'b0, w[CK-1:0]};
                c1  = {1'b0, w[2*CK-1:CK]};
                c2  = w[WW-1:2*CK];
                pl_next[i][j][0] = dir * c0;
                pl_next[i][j][1] = dir * c1;
                pt_next[i][j]    = dir * c2;
                pr_next[i][j]    = (PRW'(pt_reg[i][j]) <<< (2 * CK))
                                   + (PRW'(pl_reg[i][j][1]) <<< CK)
                                   + PRW'(pl_reg[i][j][0]);
            end
            num_next[i] = NW'(pr_reg[i][0]) + NW'(pr_reg[i][1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[WGT_STAGES-2:0], geo.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < WGT_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            dira_reg <= dira_next;
            dirb_reg <= dirb_next;
            wa_reg   <= wa_next;
            wb_reg   <= wb_next;
            pl_reg   <= pl_next;
            pt_reg   <= pt_next;
            pr_reg   <= pr_next;
            num_reg  <= num_next;
        end
    end

    always_comb
    begin
        wgt.vld  = vld_reg[WGT_STAGES-1];
        wgt.rg   = side_reg[WGT_STAGES-1].rg;
        wgt.base = side_reg[WGT_STAGES-1].base;
        wgt.den  = side_reg[WGT_STAGES-1].den;
        wgt.num  = num_reg;
    end

`ifndef SYNTHESIS
    a_vertex_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && (side_reg[0].rg == RGN_A || side_reg[0].rg == RGN_B
                       || side_reg[0].rg == RGN_C)
        |-> wa_reg == '0 && wb_reg == '0 && side_reg[0].den == w_t'(1))
        else $error("vertex region with nonzero offset weight");
`endif

endmodule

// ===== rtl/cpt_div.sv =====
// pipelined rounding divider, one quotient bit per stage, with base add and saturation
// depends on cpt_pkg
module cpt_div (
    input  logic            clk,
    input  logic            adv,
    input  cpt_pkg::num_t   num,
    input  cpt_pkg::w_t     den,
    input  cpt_pkg::coord_t base,
    output cpt_pkg::coord_t near
);
    import cpt_pkg::*;

    typedef struct packed {
        logic [CMPW-1:0] rem;
        logic [WW-1:0]   dabs;
        logic [QW-1:0]   q;
        logic            neg;
        logic            dz;
        logic            ovf;
        coord_t          base;
    } dst_t;

    logic [NW-1:0] nabs_reg, nabs_next;
    logic [WW-1:0] dabs_reg, dabs_next;
    logic          neg_reg, neg_next;
    logic          dz_reg, dz_next;
    coord_t        base_reg;
    dst_t          st_reg [QW+1];
    dst_t          st_next [QW+1];
    coord_t        near_reg, near_next;

    always_comb
    begin
        nabs_next = num[NW-1] ? (~num + 1'b1) : num;
        dabs_next = den[WW-1] ? (~den + 1'b1) : den;
        neg_next  = num[NW-1] ^ den[WW-1];
        dz_next   = (den == '0);
    end

    always_comb
    begin
        logic [CMPW-1:0] r0;
        logic [CMPW-1:0] sub;
        r0 = CMPW'(nabs_reg) + CMPW'(dabs_reg >> 1);
        st_next[0].rem  = r0;
        st_next[0].dabs = dabs_reg;
        st_next[0].q    = '0;
        st_next[0].neg  = neg_reg;
        st_next[0].dz   = dz_reg;
        st_next[0].ovf  = (r0 >= (CMPW'(dabs_reg) << QW));
        st_next[0].base = base_reg;
        for (int k = 1; k <= QW; k++)
        begin
            sub        = CMPW'(st_reg[k-1].dabs) << (QW - k);
            st_next[k] = st_reg[k-1];
            if (st_reg[k-1].rem >= sub)
            begin
                st_next[k].rem       = st_reg[k-1].rem - sub;
                st_next[k].q[QW-k]   = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [QW-1:0]        q;
        logic signed [QW:0]   off;
        logic signed [QW+1:0] sum;
        if (st_reg[QW].dz)
            q = '0;
        else if (st_reg[QW].ovf)
            q = '1;
        else
            q = st_reg[QW].q;
        off = st_reg[QW].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sum = (QW+2)'(st_reg[QW].base) + (QW+2)'(off);
        if (sum[QW+1:CW-1] == '0 || sum[QW+1:CW-1] == '1)
            near_next = sum[CW-1:0];
        else if (sum[QW+1])
            near_next = {1'b1, {(CW-1){1'b0}}};
        else
            near_next = {1'b0, {(CW-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nabs_reg <= nabs_next;
            dabs_reg <= dabs_next;
            neg_reg  <= neg_next;
            dz_reg   <= dz_next;
            base_reg <= base;
            st_reg   <= st_next;
            near_reg <= near_next;
        end
    end

    assign near = near_reg;

`ifndef SYNTHESIS
    a_zero_den_base: assert property (@(posedge clk)
        adv && st_reg[QW].dz |=> near == $past(st_reg[QW].base))
        else $error("zero divisor did not return the base point");
`endif

endmodule

// ===== rtl/closest_point_on_triangle.sv =====
// Closest point on a 3-D triangle, signed fixed-point coordinates.
// Channels: in_valid/in_ready/in_item carries one query point and three
// vertices; out_valid/out_ready/out_item returns the nearest point of the
// triangle and its region code (vertex a, b, c, edge ab, ac, bc, interior).
// The pipeline has 6 geometry stages, 4 weight stages, and a divider of
// coordinate width + 5 stages, one quotient bit per stage.
// Throughput is one item per clock while out_ready is high; all stages advance together.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is dropped or repeated, and an
// empty output stage always takes a new item.
// Reset clears all valid bits; the pipeline is empty and ready right after.
// Depends on cpt_pkg, cpt_geom, cpt_weight, cpt_div.
module closest_point_on_triangle (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cpt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output cpt_pkg::out_item_t out_item
);
    import cpt_pkg::*;

    logic               adv;
    geo_t               geo;
    wgt_t               wgt;
    coord_t [2:0]       near;
    logic [DIV_LAT-1:0] vld_line;
    region_t            rg_line [DIV_LAT];

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    cpt_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_item  (in_item),
        .geo      (geo)
    );

    cpt_weight u_weight (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .geo   (geo),
        .wgt   (wgt)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        cpt_div u_div (
            .clk  (clk),
            .adv  (adv),
            .num  (wgt.num[i]),
            .den  (wgt.den),
            .base (wgt.base[i]),
            .near (near[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_line <= '0;
        end
        else if (adv)
        begin
            vld_line <= {vld_line[DIV_LAT-2:0], wgt.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rg_line[0] <= wgt.rg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                rg_line[k] <= rg_line[k-1];
            end
        end
    end

    assign out_valid = vld_line[DIV_LAT-1];

    always_comb
    begin
        out_item.near_x = near[0];
        out_item.near_y = near[1];
        out_item.near_z = near[2];
        out_item.region = rg_line[DIV_LAT-1];
    end

`ifndef SYNTHESIS
    a_empty_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage is empty");
`endif

endmodule

// ===== tb/tb_closest_point_on_triangle.sv =====
// testbench for closest_point_on_triangle: random and directed triangle queries
// checked against an exact integer predictor, whose results wait in a small scoreboard class
// depends on cpt_pkg and the closest_point_on_triangle rtl
module tb_closest_point_on_triangle;
    timeunit 1ns;
    timeprecision 1ps;
    import cpt_pkg::*;

    typedef logic signed [255:0] big_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    int        mismatches = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic big_t div_round(big_t n, big_t d);
        big_t an;
        big_t ad;
        big_t q;
        logic neg;
        if (d == 0)
            return 0;
        neg = (n < 0) != (d < 0);
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (an + (ad >>> 1)) / ad;
        return neg ? -q : q;
    endfunction

    function automatic coord_t clamp(big_t x);
        if (x < -32768)
            return coord_t'(-32768);
        if (x > 32767)
            return coord_t'(32767);
        return coord_t'(x);
    endfunction

    function automatic out_item_t nearest_point(in_item_t it);
        big_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], base[3], dir[3];
        big_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, num, den;
        out_item_t r;
        region_t rg;
        p = '{it.query_x, it.query_y, it.query_z};
        a = '{it.vert_a_x, it.vert_a_y, it.vert_a_z};
        b = '{it.vert_b_x, it.vert_b_y, it.vert_b_z};
        c = '{it.vert_c_x, it.vert_c_y, it.vert_c_z};
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
        end
        d1 = ab[0]*(p[0]-a[0]) + ab[1]*(p[1]-a[1]) + ab[2]*(p[2]-a[2]);
        d2 = ac[0]*(p[0]-a[0]) + ac[1]*(p[1]-a[1]) + ac[2]*(p[2]-a[2]);
        d3 = ab[0]*(p[0]-b[0]) + ab[1]*(p[1]-b[1]) + ab[2]*(p[2]-b[2]);
        d4 = ac[0]*(p[0]-b[0]) + ac[1]*(p[1]-b[1]) + ac[2]*(p[2]-b[2]);
        d5 = ab[0]*(p[0]-c[0]) + ab[1]*(p[1]-c[1]) + ab[2]*(p[2]-c[2]);
        d6 = ac[0]*(p[0]-c[0]) + ac[1]*(p[1]-c[1]) + ac[2]*(p[2]-c[2]);
        vc = d1*d4 - d3*d2;
        vb = d5*d2 - d1*d6;
        va = d3*d6 - d5*d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        base = a;
        dir = ab;
        num = 0;
        den = 1;
        if (d1 <= 0 && d2 <= 0)
            rg = RGN_A;
        else if (d3 >= 0 && e1 <= 0)
        begin
            rg = RGN_B;
            base = b;
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            rg = RGN_AB;
            num = d1;
            den = d1 - d3;
        end
        else if (d6 >= 0 && e2 <= 0)
        begin
            rg = RGN_C;
            base = c;
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            rg = RGN_AC;
            dir = ac;
            num = d2;
            den = d2 - d6;
        end
        else if (va <= 0 && e1 >= 0 && e2 >= 0)
        begin
            rg = RGN_BC;
            base = b;
            dir = bc;
            num = e1;
            den = e1 + e2;
        end
        else
            rg = RGN_IN;
        if (rg == RGN_IN)
        begin
            den = va + vb + vc;
            r.near_x = clamp(a[0] + div_round(ab[0]*vb + ac[0]*vc, den));
            r.near_y = clamp(a[1] + div_round(ab[1]*vb + ac[1]*vc, den));
            r.near_z = clamp(a[2] + div_round(ab[2]*vb + ac[2]*vc, den));
        end
        else
        begin
            r.near_x = clamp(base[0] + div_round(dir[0]*num, den));
            r.near_y = clamp(base[1] + div_round(dir[1]*num, den));
            r.near_z = clamp(base[2] + div_round(dir[2]*num, den));
        end
        r.region = rg;
        return r;
    endfunction

    class nearest_board;
        out_item_t pending[$];

        function void note_query(in_item_t it);
            pending.push_back(nearest_point(it));
        endfunction

        task check_point(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report("unexpected item", got.region, -1);
                return;
            end
            want = pending.pop_front();
            if (got.near_x !== want.near_x)
                report("near_x", got.near_x, want.near_x);
            if (got.near_y !== want.near_y)
                report("near_y", got.near_y, want.near_y);
            if (got.near_z !== want.near_z)
                report("near_z", got.near_z, want.near_z);
            if (got.region !== want.region)
                report("region", got.region, want.region);
        endtask
    endclass

    nearest_board board = new();
    int send_idle = 0;
    int take_idle = 0;
    bit hold_off = 0;
    bit sending_done = 0;

    closest_point_on_triangle dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_query(in_item);
        if (rst_n && out_valid && out_ready)
            board.check_point(out_item);
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= take_idle);
    end

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 2047) - 1024);
            default: return coord_t'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    function automatic in_item_t rand_query();
        in_item_t it;
        int mode;
        mode = $urandom_range(2);
        it = {12{16'h0}};
        it.query_x = rand_coord(mode);
        it.query_y = rand_coord(mode);
        it.query_z = rand_coord(mode);
        it.vert_a_x = rand_coord(mode);
        it.vert_a_y = rand_coord(mode);
        it.vert_a_z = rand_coord(mode);
        it.vert_b_x = rand_coord(mode);
        it.vert_b_y = rand_coord(mode);
        it.vert_b_z = rand_coord(mode);
        it.vert_c_x = rand_coord(mode);
        it.vert_c_y = rand_coord(mode);
        it.vert_c_z = rand_coord(mode);
        if ($urandom_range(19) == 0)
        begin
            it.vert_b_x = it.vert_a_x;
            it.vert_b_y = it.vert_a_y;
            it.vert_b_z = it.vert_a_z;
        end
        else if ($urandom_range(19) == 0)
        begin
            it.vert_c_x = it.vert_b_x + it.vert_b_x - it.vert_a_x;
            it.vert_c_y = it.vert_b_y + it.vert_b_y - it.vert_a_y;
            it.vert_c_z = it.vert_b_z + it.vert_b_z - it.vert_a_z;
        end
        return it;
    endfunction

    // valid stays high into the next item unless the sender idles
    task automatic send_query(input in_item_t it);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_item_t make_tri(int px, int py, int pz);
        in_item_t it;
        it = {12{16'h0}};
        it.vert_b_x = 16'sd1024;
        it.vert_c_y = 16'sd1024;
        it.query_x = coord_t'(px);
        it.query_y = coord_t'(py);
        it.query_z = coord_t'(pz);
        return it;
    endfunction

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++)
            send_query(rand_query());
    endtask

    initial
    begin
        in_item_t it;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // each region on a right triangle with legs of 1024, then extremes
        send_query(make_tri(-100, -100, 50));
        send_query(make_tri(2000, -50, 0));
        send_query(make_tri(300, -200, 7));
        send_query(make_tri(-50, 2000, 0));
        send_query(make_tri(-300, 400, -9));
        send_query(make_tri(900, 900, 100));
        send_query(make_tri(200, 300, -500));
        send_query(make_tri(333, 333, 0));
        send_query({12{16'h8000}});
        send_query({12{16'h7fff}});
        send_query({12{16'hffff}});
        send_query({12{16'h5555}});
        send_query({12{16'haaaa}});
        it = {12{16'h0}};
        it.vert_a_x = 16'sh8000;
        it.vert_b_x = 16'sh7fff;
        it.vert_c_y = 16'sh7fff;
        it.query_x = 16'sh7fff;
        it.query_y = 16'sh7fff;
        it.query_z = 16'sh8000;
        send_query(it);
        it.vert_c_y = 16'sh8000;
        it.query_y = 16'sh8000;
        send_query(it);
        it = {12{16'h0}};
        it.vert_c_x = 16'sd500;
        it.query_y = 16'sd77;
        send_query(it);

        send_idle = 14;
        take_idle = 74;
        run_phase(150);
        send_idle = 74;
        take_idle = 14;
        run_phase(150);
        send_idle = 0;
        take_idle = 0;
        hold_off = 1'b1;
        fork
            run_phase(60);
            begin
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        run_phase(140);
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && board.pending.size() == 0)
            $display("closest_point_on_triangle test passed");
        else
            $display("closest_point_on_triangle test failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("closest_point_on_triangle test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/cpt_pkg.sv
rtl/cpt_geom.sv
rtl/cpt_weight.sv
rtl/cpt_div.sv
rtl/closest_point_on_triangle.sv
tb/tb_closest_point_on_triangle.sv
